/* hdl/altok_pkg.sv */
package altok_pkg;

  // Default word limit per line
  localparam int unsigned MAX_WORDS_DEF = 64;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned ERR_W    = 3;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [CH_W-1:0] CH_AT     = 8'h40;  // '@'
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;  // ','
  localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;  // ':'
  localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;  // '"'
  localparam logic [CH_W-1:0] CH_BLANK  = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 3'd0,
    ERR_ILLEGAL  = 3'd1,
    ERR_MISSING  = 3'd2,
    ERR_CONSEC   = 3'd3,
    ERR_TRAILING = 3'd4
  } err_e;

  typedef enum logic [8:0] {
    ST_LBL_OR_CMD       = 9'b000000001,
    ST_AFTER_LBL        = 9'b000000010,
    ST_AFTER_LBL_OR_CMD = 9'b000000100,
    ST_IN_CMD           = 9'b000001000,
    ST_AFTER_CMD        = 9'b000010000,
    ST_IN_OPND          = 9'b000100000,
    ST_EXPECT_COMMA     = 9'b001000000,
    ST_AFTER_OPND_WAIT  = 9'b010000000,
    ST_AFTER_OPND       = 9'b100000000
  } state_e;

  // Parser state apart from the word counter
  typedef struct packed {
    state_e st;
    logic   label_seen;
    logic   last_comma;
  } parse_t;

  localparam parse_t PARSE_RST = '{st: ST_LBL_OR_CMD, label_seen: 1'b0, last_comma: 1'b0};

  typedef struct packed {
    logic               label_found;
    logic [COUNT_W-1:0] word_count;
    logic               line_done;
    err_e               error_code;
    logic               cut_previous;
    logic               word_end;
    logic [IDX_W-1:0]   word_index;
    logic               word_start;
  } result_t;

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return c inside {CH_BLANK, [CH_TAB:CH_CR]};
  endfunction

  function automatic logic is_alnum(input logic [CH_W-1:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_opnd(input logic [CH_W-1:0] c);
    return is_alnum(c) || (c inside {CH_AT, CH_MINUS, CH_PLUS});
  endfunction

endpackage

/* hdl/altok_step.sv */
module altok_step #(
  parameter int unsigned MaxWords = altok_pkg::MAX_WORDS_DEF,
  parameter int unsigned CntW     = $clog2(MaxWords + 1)
) (
  input  logic [altok_pkg::CH_W-1:0] ch_i,
  input  logic                       line_end_i,
  input  altok_pkg::parse_t          parse_i,
  input  logic [CntW-1:0]            words_i,
  output altok_pkg::parse_t          parse_o,
  output logic [CntW-1:0]            words_o,
  output altok_pkg::result_t         res_o
);
  import altok_pkg::*;

  logic start, wend, cut;
  err_e err;

  always_comb begin
    parse_o = parse_i;
    words_o = words_i;
    res_o   = '0;
    start   = 1'b0;
    wend    = 1'b0;
    cut     = 1'b0;
    err     = ERR_NONE;

    if (line_end_i) begin
      res_o.error_code  = parse_i.last_comma ? ERR_TRAILING : ERR_NONE;
      res_o.line_done   = 1'b1;
      res_o.word_count  = COUNT_W'(words_i);
      res_o.label_found = parse_i.label_seen;
      parse_o = PARSE_RST;
      words_o = CntW'(1);
    end else if (ch_i == CH_QUOTE) begin
      // dropped character: only the current word index is reported
      res_o.word_index = IDX_W'(words_i - CntW'(1));
    end else begin
      if (!is_space(ch_i)) begin
        parse_o.last_comma = (ch_i == CH_COMMA);
      end
      case (parse_i.st)
        ST_AFTER_LBL: begin
          if (is_alnum(ch_i)) begin
            start = 1'b1; parse_o.st = ST_IN_CMD;
          end else if (ch_i == CH_COMMA) begin
            err = ERR_ILLEGAL;
          end
        end
        ST_AFTER_LBL_OR_CMD: begin
          if (parse_i.label_seen && is_alnum(ch_i)) begin
            start = 1'b1; parse_o.st = ST_IN_CMD;
          end else if (!parse_i.label_seen && is_opnd(ch_i)) begin
            start = 1'b1; parse_o.st = ST_IN_OPND;
          end else if (ch_i == CH_COMMA) begin
            err = ERR_ILLEGAL;
          end
        end
        ST_IN_CMD: begin
          if (is_space(ch_i)) begin
            wend = 1'b1; parse_o.st = ST_AFTER_CMD;
          end else if (ch_i == CH_COMMA) begin
            err = ERR_ILLEGAL;
          end
        end
        ST_AFTER_CMD: begin
          if (is_opnd(ch_i)) begin
            start = 1'b1; parse_o.st = ST_IN_OPND;
          end else if (ch_i == CH_COMMA) begin
            err = ERR_ILLEGAL;
          end
        end
        ST_IN_OPND: begin
          if (ch_i == CH_COMMA) begin
            wend = 1'b1; parse_o.st = ST_AFTER_OPND_WAIT;
          end else if (!is_opnd(ch_i)) begin
            parse_o.st = ST_EXPECT_COMMA;
          end
        end
        ST_EXPECT_COMMA: begin
          if (is_alnum(ch_i)) begin
            err = ERR_MISSING; cut = 1'b1; start = 1'b1; parse_o.st = ST_IN_OPND;
          end else if (ch_i == CH_COMMA) begin
            wend = 1'b1; parse_o.st = ST_AFTER_OPND;
          end
        end
        ST_AFTER_OPND_WAIT: begin
          if (is_opnd(ch_i)) begin
            start = 1'b1; parse_o.st = ST_IN_OPND;
          end else if (ch_i == CH_COMMA) begin
            err = ERR_CONSEC;
          end else if (!is_space(ch_i)) begin
            parse_o.st = ST_AFTER_OPND;
          end
        end
        ST_AFTER_OPND: begin
          if (is_opnd(ch_i)) begin
            start = 1'b1; parse_o.st = ST_IN_OPND;
          end else if (ch_i == CH_COMMA) begin
            err = ERR_CONSEC;
          end
        end
        default: begin
          // label or command
          if (is_space(ch_i)) begin
            wend = 1'b1; parse_o.st = ST_AFTER_LBL_OR_CMD;
          end else if (ch_i == CH_COMMA) begin
            err = ERR_ILLEGAL;
          end else if (ch_i == CH_COLON) begin
            parse_o.label_seen = 1'b1; wend = 1'b1; parse_o.st = ST_AFTER_LBL;
          end
        end
      endcase

      // saturate at the word limit
      if (start && (words_i < CntW'(MaxWords))) begin
        words_o = words_i + CntW'(1);
      end

      res_o.word_start   = start;
      res_o.word_index   = IDX_W'(words_o - CntW'(1));
      res_o.word_end     = wend;
      res_o.cut_previous = cut;
      res_o.error_code   = err;
    end
  end

endmodule

/* hdl/assembly_line_tokenizer_top.sv */
// Each accepted beat's result is registered in the head register, or in the skid entry.
// Throughput: one character beat per cycle while the skid entry is empty.
// A two-entry output stage (result register plus skid) accepts one more input beat
//   while the master side stalls.
// Reset (rst_ni low, asynchronous): parser returns to the label-or-command state, word
//   count to one, both output entries empty.
module assembly_line_tokenizer_top #(
  parameter int unsigned MaxWords = altok_pkg::MAX_WORDS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave side
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [altok_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,  // [7:0] ch
  input  logic                             s_axis_tlast_i,  // line_end
  // master side
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] word_start, [6:1] word_index, [7] word_end, [8] cut_previous,
  // [11:9] error_code, [18:12] word_count, [19] label_found, [23:20] zero
  output logic [altok_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                             m_axis_tlast_o   // line_done
);
  import altok_pkg::*;

  localparam int unsigned CntW = $clog2(MaxWords + 1);

  // Parser state
  parse_t          parse_q, parse_d;
  logic [CntW-1:0] words_q, words_d;
  result_t         res_d;

  // Output stage: head register and skid entry
  result_t out_q, skid_q;
  logic    out_vld_q, skid_vld_q;

  logic in_acc, out_take, head_free;

  assign s_axis_tready_o = !skid_vld_q;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_take        = out_vld_q && m_axis_tready_i;
  assign head_free       = !out_vld_q || out_take;

  altok_step #(
    .MaxWords (MaxWords),
    .CntW     (CntW)
  ) u_step (
    .ch_i       (s_axis_tdata_i[CH_W-1:0]),
    .line_end_i (s_axis_tlast_i),
    .parse_i    (parse_q),
    .words_i    (words_q),
    .parse_o    (parse_d),
    .words_o    (words_d),
    .res_o      (res_d)
  );

  // Parser state advances on every accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q <= PARSE_RST;
      words_q <= CntW'(1);
    end else if (in_acc) begin
      parse_q <= parse_d;
      words_q <= words_d;
    end
  end

  // Output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (head_free) begin
      // skid full means no beat came in this cycle
      out_vld_q  <= skid_vld_q || in_acc;
      skid_vld_q <= 1'b0;
    end else if (in_acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk_i) begin
    if (head_free) begin
      out_q <= skid_vld_q ? skid_q : res_d;
    end
    if (!head_free && in_acc) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tlast_o  = out_q.line_done;
  assign m_axis_tdata_o  = {4'b0000, out_q.label_found, out_q.word_count,
                            out_q.error_code, out_q.cut_previous, out_q.word_end,
                            out_q.word_index, out_q.word_start};

  // Assertions
  a_skid_behind_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry holds a beat while the head register is empty");

  a_line_end_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=>
      (words_q == CntW'(1) && parse_q.st == ST_LBL_OR_CMD && !parse_q.label_seen
       && !parse_q.last_comma))
    else $error("parser not back at line start after end of line");

  a_done_beat_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (!out_q.word_start && !out_q.word_end && !out_q.cut_previous
       && out_q.word_index == '0 && out_q.word_count != '0))
    else $error("end-of-line beat carries per-character fields");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    words_q != '0 && words_q <= CntW'(MaxWords))
    else $error("word counter out of range");

endmodule
